/* rtl/lsa_pkg.sv */
// Package for the LED strip animation byte block: widths, codes and constant tables.
package lsa_pkg;

  // Field and port widths.
  localparam int FrameW = 16;
  localparam int IdxW   = 8;
  localparam int ByteW  = 8;
  localparam int LevelW = 8;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // Strip length in LEDs; bytes at or beyond three per LED read as zero.
  localparam int LedCount = 77;
  localparam int LimitW = 12;
  localparam logic [LimitW-1:0] StripLimit = LimitW'(3 * LedCount);

  // Animation constants.
  localparam int PulseLen  = 53;
  localparam int PulseIdxW = 6;
  localparam int PulseTW   = 15;
  localparam logic [10:0] WaveStep = 11'd1043;
  localparam int PhaseDen  = 150;
  localparam int PulseDen  = 53;
  localparam int SineTerms = 10;
  localparam logic [63:0] PiQ31 = 64'd6746518852;
  localparam logic [63:0] SineDiv [1:10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                             64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [IdxW-1:0]   index_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [LevelW-1:0] level_t;

  // Register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    RegMode  = 2'd0,
    RegRed   = 2'd1,
    RegGreen = 2'd2,
    RegBlue  = 2'd3
  } reg_idx_e;

  // Colour channel of a byte.
  typedef enum logic [1:0] {
    ChanRed   = 2'd0,
    ChanGreen = 2'd1,
    ChanBlue  = 2'd2
  } chan_e;

  // Register contents handed from the register file to the datapath.
  typedef struct packed {
    logic   pulse_mode;
    level_t red_level;
    level_t green_level;
    level_t blue_level;
  } cfg_t;

  typedef logic [PulseLen-1:0][PulseTW-1:0] pulse_tab_t;
  typedef logic [255:0][ByteW-1:0]          wave_tab_t;
  typedef logic [255:0][FrameW-1:0]         phase_tab_t;
  typedef logic [255:0][1:0]                chan_tab_t;
  typedef logic [255:0][PulseIdxW-1:0]      mod_tab_t;

  // round(32767*sin(x)) for x in Q31 radians within a quarter turn, by a Taylor series.
  function automatic logic [15:0] sine_mag(input logic [63:0] x);
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] mag;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= SineTerms; n++) begin
      term = (term * x) >> 31;
      term = (term * x) >> 31;
      term = term / SineDiv[n];
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    mag = ($unsigned(acc) * 64'd32767 + (64'd1 << 30)) >> 31;
    return mag[15:0];
  endfunction

  // Pulse envelope: |sin| over 53 frames in Q0.15.
  function automatic pulse_tab_t build_pulse_tab();
    pulse_tab_t tab;
    logic [63:0] r;
    logic [15:0] m;
    for (int k = 0; k < PulseLen; k++) begin
      r = (k > PulseLen / 2) ? 64'(PulseLen - k) : 64'(k);
      m = sine_mag((PiQ31 * r) / PulseDen);
      tab[k] = m[PulseTW-1:0];
    end
    return tab;
  endfunction

  // Output byte of the first quarter of the sine, already scaled by 255.
  function automatic logic [ByteW-1:0] wave_byte(input logic [63:0] r);
    logic [63:0] m;
    m = 64'(sine_mag((PiQ31 * r) >> 9));
    m = (m * 64'd255) >> 15;
    return m[ByteW-1:0];
  endfunction

  function automatic wave_tab_t build_wave_tab();
    wave_tab_t tab;
    for (int r = 0; r < 256; r++) begin
      tab[r] = wave_byte(64'(r));
    end
    return tab;
  endfunction

  // Phase offset of each byte position: its place along the strip plus its colour shift.
  function automatic phase_tab_t build_phase_tab();
    phase_tab_t tab;
    logic [63:0] base;
    for (int i = 0; i < 256; i++) begin
      base = (64'(i) * 64'd131072 + 64'd75) / PhaseDen;
      base = base + 64'(i % 3) * 64'd21845;
      tab[i] = base[FrameW-1:0];
    end
    return tab;
  endfunction

  function automatic chan_tab_t build_chan_tab();
    chan_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 2'(i % 3);
    end
    return tab;
  endfunction

  // Residues modulo 53 of the low byte and of the high byte weighted by 256.
  function automatic mod_tab_t build_mod_tab(input logic hi_byte);
    mod_tab_t tab;
    for (int b = 0; b < 256; b++) begin
      tab[b] = hi_byte ? PulseIdxW'((b * 256) % PulseLen) : PulseIdxW'(b % PulseLen);
    end
    return tab;
  endfunction

  localparam pulse_tab_t PulseTab  = build_pulse_tab();
  localparam wave_tab_t  WaveTab   = build_wave_tab();
  localparam logic [ByteW-1:0] WavePeak = wave_byte(64'd256);
  localparam phase_tab_t PhaseTab  = build_phase_tab();
  localparam chan_tab_t  ChanTab   = build_chan_tab();
  localparam mod_tab_t   Mod53Lo   = build_mod_tab(1'b0);
  localparam mod_tab_t   Mod53Hi   = build_mod_tab(1'b1);

endpackage

/* rtl/lsa_if.sv */
// Handshake channels of the LED strip animation block: input items and result bytes.
interface lsa_in_if;
  logic            valid;
  logic            ready;
  lsa_pkg::frame_t frame_number;
  lsa_pkg::index_t byte_index;

  modport source (output valid, output frame_number, output byte_index, input ready);
  modport sink   (input valid, input frame_number, input byte_index, output ready);
endinterface

interface lsa_out_if;
  logic           valid;
  logic           ready;
  lsa_pkg::byte_t pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

/* rtl/lsa_cfg.sv */
// APB register file holding the animation mode and the three pulse levels.
module lsa_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsa_pkg::AddrW-1:0] paddr,
  input  logic [lsa_pkg::DataW-1:0] pwdata,
  output logic [lsa_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output lsa_pkg::cfg_t             cfg_o
);
  import lsa_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write decode: the access cycle of a write transfer updates one register.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegMode:  cfg_d.pulse_mode  = pwdata[0];
        RegRed:   cfg_d.red_level   = pwdata[LevelW-1:0];
        RegGreen: cfg_d.green_level = pwdata[LevelW-1:0];
        RegBlue:  cfg_d.blue_level  = pwdata[LevelW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      RegMode:  prdata = DataW'(cfg_q.pulse_mode);
      RegRed:   prdata = DataW'(cfg_q.red_level);
      RegGreen: prdata = DataW'(cfg_q.green_level);
      RegBlue:  prdata = DataW'(cfg_q.blue_level);
      default:  prdata = '0;
    endcase
  end

endmodule

/* rtl/lsa_core.sv */
// Datapath computing one pixel byte from a frame number and a byte index.
module lsa_core (
  input  lsa_pkg::cfg_t   cfg_i,
  input  lsa_pkg::frame_t frame_i,
  input  lsa_pkg::index_t index_i,
  output lsa_pkg::byte_t  pixel_o
);
  import lsa_pkg::*;

  logic                  in_strip;
  chan_e                 chan;
  logic [PulseIdxW:0]    mod_sum;
  logic [PulseIdxW-1:0]  pulse_idx;
  logic [PulseTW-1:0]    pulse_env;
  level_t                level;
  logic [LevelW+PulseTW-1:0] pulse_prod;
  byte_t                 pulse_byte;
  logic [FrameW+10:0]    step;
  frame_t                phase;
  logic [9:0]            sine_idx;
  logic [8:0]            quarter;
  byte_t                 wave_byte_v;

  assign in_strip = {{(LimitW-IdxW){1'b0}}, index_i} < StripLimit;
  assign chan     = chan_e'(ChanTab[index_i]);

  // Frame number modulo 53 from per-byte residues and one conditional subtract.
  assign mod_sum   = {1'b0, Mod53Hi[frame_i[15:8]]} + {1'b0, Mod53Lo[frame_i[7:0]]};
  assign pulse_idx = (mod_sum >= (PulseIdxW+1)'(PulseLen)) ?
                     PulseIdxW'(mod_sum - (PulseIdxW+1)'(PulseLen)) : mod_sum[PulseIdxW-1:0];
  assign pulse_env = PulseTab[pulse_idx];

  // Level of this byte's colour channel.
  always_comb begin
    case (chan)
      ChanRed:   level = cfg_i.red_level;
      ChanGreen: level = cfg_i.green_level;
      ChanBlue:  level = cfg_i.blue_level;
      default:   level = '0;
    endcase
  end

  assign pulse_prod = level * pulse_env;
  assign pulse_byte = pulse_prod[LevelW+PulseTW-1:PulseTW];

  // Wave phase: position offset plus frame advance, wrapping at 16 bits.
  assign step     = frame_i * WaveStep;
  assign phase    = PhaseTab[index_i] + step[FrameW-1:0];
  assign sine_idx = phase[FrameW-1:FrameW-10];

  // Fold the positive half onto the quarter table; the negative half clamps to zero.
  always_comb begin
    if (sine_idx[8:0] > 9'd256) begin
      quarter = 9'(10'd512 - {1'b0, sine_idx[8:0]});
    end else begin
      quarter = sine_idx[8:0];
    end
    if (sine_idx[9]) begin
      wave_byte_v = '0;
    end else if (quarter[8]) begin
      wave_byte_v = WavePeak;
    end else begin
      wave_byte_v = WaveTab[quarter[7:0]];
    end
  end

  // Bytes past the end of the strip are dark in either mode.
  always_comb begin
    if (!in_strip) begin
      pixel_o = '0;
    end else if (cfg_i.pulse_mode) begin
      pixel_o = pulse_byte;
    end else begin
      pixel_o = wave_byte_v;
    end
  end

endmodule

/* rtl/led_strip_animation_byte.sv */
// Top level of the LED strip animation byte generator: register file, input and result stages.
//
//   channel  direction  payload                        handshake
//   in_i     sink       frame_number[16], byte_index[8]  valid / ready
//   out_o    source     pixel_byte[8]                   valid / ready
//   apb      slave      4 registers, 32-bit words        psel / penable, pready high
//
// An item sits in the input register while the datapath works on it, and then moves into
// the result register; a stall on the result side can hold it in the input register.
// One item is taken in every cycle while the result register is empty or its result is taken.
// Reset clears the valid flags and the configuration registers; the data registers are not
// reset and there is no clearing pass.
// When the result is not taken, the input register still fills, so one further item is
// accepted before the input side stalls.
module led_strip_animation_byte (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsa_pkg::AddrW-1:0] paddr,
  input  logic [lsa_pkg::DataW-1:0] pwdata,
  output logic [lsa_pkg::DataW-1:0] prdata,
  output logic                      pready,
  lsa_in_if.sink                    in_i,
  lsa_out_if.source                 out_o
);
  import lsa_pkg::*;

  cfg_t   cfg;
  logic   in_valid_q;
  frame_t frame_q;
  index_t index_q;
  logic   out_valid_q;
  byte_t  out_byte_q;
  byte_t  out_byte_d;
  logic   out_adv;
  logic   in_adv;

  lsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage handshakes: the result register frees when empty or taken.
  assign out_adv    = !out_valid_q || out_o.ready;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_i.ready = in_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_i.valid) begin
      frame_q <= in_i.frame_number;
      index_q <= in_i.byte_index;
    end
  end

  lsa_core u_core (
    .cfg_i   (cfg),
    .frame_i (frame_q),
    .index_i (index_q),
    .pixel_o (out_byte_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_byte = out_byte_q;

`ifndef SYNTHESIS
  // A blocked item in the input register is kept.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_adv |=> in_valid_q)
    else $error("input stage lost a blocked item");

  // An item moving on always produces a result.
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_adv |=> out_valid_q)
    else $error("item moved on without a result");

  // Bytes beyond the strip give zero.
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_adv && ({{(LimitW-IdxW){1'b0}}, index_q} >= StripLimit)
    |=> out_byte_q == '0)
    else $error("byte beyond the strip is not dark");
`endif

endmodule
